@@ design/seqrob_pkg.sv @@
// ----------------------------------------------------------------------------
// seqrob_pkg
// Shared types, codes and helpers for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package seqrob_pkg;

    localparam int SEQ_W  = 32;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 32;

    // op codes on the input request
    localparam logic OP_UNIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        KIND_DELIVERED = 2'd0,
        KIND_DISCARDED = 2'd1,
        KIND_QUEUED    = 2'd2,
        KIND_REJECTED  = 2'd3
    } kind_t;

    typedef struct packed {
        logic              op;
        logic [SEQ_W-1:0]  seq;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] expiry;
        logic              ack_wanted;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [SEQ_W-1:0] seq_res;
        logic [TAG_W-1:0] tag_res;
        logic             ack_due;
        logic             last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_DECIDE      = 3'd1,
        ST_DRAIN_CHECK = 3'd2,
        ST_DRAIN_EMIT  = 3'd3,
        ST_SCAN        = 3'd4,
        ST_ARM         = 3'd5
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch input request
        logic emit_input;  // result for the received unit, apply its update
        logic tick_jump;   // skip expected counter to the timer's unit
        logic disarm;      // drop the gap timer
        logic tag_read;    // read tag of head slot
        logic emit_slot;   // deliver head slot and advance
        logic scan_start;  // start search for earliest queued unit
        logic scan_step;   // next slot of the search
        logic exp_read;    // read expiry of found slot
        logic arm;         // arm timer from found slot
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic timer_due;
        logic timer_slot_valid;
        logic recv_drains;
        logic head_valid;
        logic timer_armed;
        logic scan_hit;
        logic scan_done;
        logic out_free;
    } status_t;

    // timer fires at expiry minus one, saturating at zero
    function automatic logic [TIME_W-1:0] deadline_of(input logic [TIME_W-1:0] e);
        return (e == '0) ? '0 : e - 1'b1;
    endfunction

endpackage

@@ design/seqrob_ctrl.sv @@
// ----------------------------------------------------------------------------
// seqrob_ctrl
// Sequencer for the reorder buffer: classify, emit, drain, timer search.
// ----------------------------------------------------------------------------
module seqrob_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  seqrob_pkg::status_t status,
    output seqrob_pkg::cmd_t    cmd
);

    seqrob_pkg::state_t state_reg;
    seqrob_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= seqrob_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            seqrob_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = seqrob_pkg::ST_DECIDE;
                end
            end
            seqrob_pkg::ST_DECIDE:
            begin
                if (status.is_tick)
                begin
                    if (!status.timer_due)
                    begin
                        state_next = seqrob_pkg::ST_IDLE;
                    end
                    else if (!status.timer_slot_valid)
                    begin
                        cmd.disarm = 1'b1;
                        state_next = seqrob_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.tick_jump = 1'b1;
                        state_next    = seqrob_pkg::ST_DRAIN_CHECK;
                    end
                end
                else if (status.out_free)
                begin
                    cmd.emit_input = 1'b1;
                    state_next     = status.recv_drains ? seqrob_pkg::ST_DRAIN_CHECK
                                                        : seqrob_pkg::ST_IDLE;
                end
            end
            seqrob_pkg::ST_DRAIN_CHECK:
            begin
                if (status.head_valid)
                begin
                    cmd.tag_read = 1'b1;
                    state_next   = seqrob_pkg::ST_DRAIN_EMIT;
                end
                else if (!status.timer_armed)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = seqrob_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = seqrob_pkg::ST_IDLE;
                end
            end
            seqrob_pkg::ST_DRAIN_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_slot = 1'b1;
                    state_next    = seqrob_pkg::ST_DRAIN_CHECK;
                end
            end
            seqrob_pkg::ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    cmd.exp_read = 1'b1;
                    state_next   = seqrob_pkg::ST_ARM;
                end
                else if (status.scan_done)
                begin
                    state_next = seqrob_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            seqrob_pkg::ST_ARM:
            begin
                cmd.arm    = 1'b1;
                state_next = seqrob_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = seqrob_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/seqrob_datapath.sv @@
// ----------------------------------------------------------------------------
// seqrob_datapath
// Counter, slot valid bits, tag/expiry stores, gap timer and result register.
// ----------------------------------------------------------------------------
module seqrob_datapath #(
    parameter int WINDOW   = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  seqrob_pkg::item_t   item,
    input  logic                result_stall,
    output logic                result_valid,
    output seqrob_pkg::result_t result,
    input  seqrob_pkg::cmd_t    cmd,
    output seqrob_pkg::status_t status
);

    localparam int IDX_W    = $clog2(WINDOW);
    localparam int TAG_KEEP = (TAG_BITS < seqrob_pkg::TAG_W) ? TAG_BITS : seqrob_pkg::TAG_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W:0]   WIN_SUM  = (IDX_W + 1)'(WINDOW);
    localparam logic [seqrob_pkg::SEQ_W:0] WIN_EXT = (seqrob_pkg::SEQ_W + 1)'(WINDOW);

    // control state
    logic [seqrob_pkg::SEQ_W-1:0]  expected_reg, expected_next;
    logic [IDX_W-1:0]              exp_idx_reg, exp_idx_next;
    logic [WINDOW-1:0]             valid_reg, valid_next;
    logic                          timer_armed_reg, timer_armed_next;
    logic [seqrob_pkg::TIME_W-1:0] timer_deadline_reg, timer_deadline_next;
    logic [seqrob_pkg::SEQ_W-1:0]  timer_seq_reg, timer_seq_next;
    logic [IDX_W-1:0]              timer_idx_reg, timer_idx_next;
    logic                          result_valid_reg, result_valid_next;

    // payload
    seqrob_pkg::item_t             item_reg;
    seqrob_pkg::result_t           result_reg;
    logic [TAG_KEEP-1:0]           tag_mem [WINDOW];
    logic [seqrob_pkg::TIME_W-1:0] exp_mem [WINDOW];
    logic [TAG_KEEP-1:0]           tag_rd_reg;
    logic [seqrob_pkg::TIME_W-1:0] exp_rd_reg;
    logic [seqrob_pkg::SEQ_W-1:0]  scan_seq_reg;
    logic [IDX_W-1:0]              scan_idx_reg;
    logic [IDX_W-1:0]              scan_cnt_reg;

    // classification
    logic [seqrob_pkg::SEQ_W-1:0] seq_diff;
    logic [IDX_W:0]               in_sum;
    logic [IDX_W-1:0]             in_idx;
    logic                         seq_zero, seq_late, seq_hit, seq_far, slot_busy;
    logic [IDX_W-1:0]             exp_idx_step, exp_idx_adv, scan_idx_step;
    logic                         head_valid, more_after_adv;
    seqrob_pkg::kind_t            in_kind;
    logic                         do_queue, in_last;
    logic                         load;
    logic [seqrob_pkg::TAG_W-1:0] in_tag;

    assign seq_diff = item_reg.seq - expected_reg;
    assign in_sum   = {1'b0, exp_idx_reg} + {1'b0, seq_diff[IDX_W-1:0]};
    assign in_idx   = (in_sum >= WIN_SUM) ? IDX_W'(in_sum - WIN_SUM) : in_sum[IDX_W-1:0];

    assign seq_zero  = (item_reg.seq == '0);
    assign seq_late  = (item_reg.seq < expected_reg);
    assign seq_hit   = (item_reg.seq == expected_reg);
    assign seq_far   = ({1'b0, item_reg.seq} >= ({1'b0, expected_reg} + WIN_EXT));
    assign slot_busy = valid_reg[in_idx];

    // slot of expected+1; counter wrap lands on slot 0
    assign exp_idx_step   = (exp_idx_reg == IDX_LAST) ? '0 : exp_idx_reg + 1'b1;
    assign exp_idx_adv    = (expected_reg == '1) ? '0 : exp_idx_step;
    assign head_valid     = valid_reg[exp_idx_reg];
    assign more_after_adv = valid_reg[exp_idx_adv] && (exp_idx_adv != exp_idx_reg);
    assign scan_idx_step  = (scan_idx_reg == IDX_LAST) ? '0 : scan_idx_reg + 1'b1;

    assign in_tag = seqrob_pkg::TAG_W'(item_reg.tag[TAG_KEEP-1:0]);

    always_comb
    begin
        do_queue = 1'b0;
        in_last  = 1'b1;
        if (seq_zero)
        begin
            in_kind = seqrob_pkg::KIND_DELIVERED;
            in_last = !head_valid;
        end
        else if (seq_late)
        begin
            in_kind = seqrob_pkg::KIND_DISCARDED;
        end
        else if (seq_hit)
        begin
            in_kind = seqrob_pkg::KIND_DELIVERED;
            in_last = !more_after_adv;
        end
        else if (seq_far)
        begin
            in_kind = seqrob_pkg::KIND_REJECTED;
        end
        else if (slot_busy)
        begin
            in_kind = seqrob_pkg::KIND_DISCARDED;
        end
        else
        begin
            in_kind  = seqrob_pkg::KIND_QUEUED;
            do_queue = 1'b1;
        end
    end

    assign load = cmd.emit_input || cmd.emit_slot;

    always_comb
    begin
        status                  = '0;
        status.is_tick          = (item_reg.op == seqrob_pkg::OP_TICK);
        status.timer_due        = timer_armed_reg && (item_reg.now >= timer_deadline_reg);
        status.timer_slot_valid = valid_reg[timer_idx_reg];
        status.recv_drains      = seq_zero || seq_hit;
        status.head_valid       = head_valid;
        status.timer_armed      = timer_armed_reg;
        status.scan_hit         = valid_reg[scan_idx_reg];
        status.scan_done        = (scan_cnt_reg == IDX_LAST) || (scan_seq_reg == '1);
        status.out_free         = !result_valid_reg || !result_stall;
    end

    always_comb
    begin
        expected_next       = expected_reg;
        exp_idx_next        = exp_idx_reg;
        valid_next          = valid_reg;
        timer_armed_next    = timer_armed_reg;
        timer_deadline_next = timer_deadline_reg;
        timer_seq_next      = timer_seq_reg;
        timer_idx_next      = timer_idx_reg;
        result_valid_next   = load || (result_valid_reg && result_stall);

        if (cmd.emit_input)
        begin
            if (seq_hit && !seq_zero)
            begin
                expected_next = expected_reg + 1'b1;
                exp_idx_next  = exp_idx_adv;
            end
            if (do_queue)
            begin
                valid_next[in_idx] = 1'b1;
                if (!timer_armed_reg || (item_reg.seq < timer_seq_reg))
                begin
                    timer_armed_next    = 1'b1;
                    timer_seq_next      = item_reg.seq;
                    timer_idx_next      = in_idx;
                    timer_deadline_next = seqrob_pkg::deadline_of(item_reg.expiry);
                end
            end
        end

        if (cmd.disarm || cmd.tick_jump)
        begin
            timer_armed_next    = 1'b0;
            timer_deadline_next = '0;
        end

        if (cmd.tick_jump)
        begin
            expected_next = timer_seq_reg;
            exp_idx_next  = timer_idx_reg;
        end

        if (cmd.emit_slot)
        begin
            valid_next[exp_idx_reg] = 1'b0;
            timer_armed_next        = 1'b0;
            timer_deadline_next     = '0;
            expected_next           = expected_reg + 1'b1;
            exp_idx_next            = exp_idx_adv;
        end

        if (cmd.arm)
        begin
            timer_armed_next    = 1'b1;
            timer_seq_next      = scan_seq_reg;
            timer_idx_next      = scan_idx_reg;
            timer_deadline_next = seqrob_pkg::deadline_of(exp_rd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg       <= seqrob_pkg::SEQ_W'(1);
            exp_idx_reg        <= IDX_W'(1);
            valid_reg          <= '0;
            timer_armed_reg    <= 1'b0;
            timer_deadline_reg <= '0;
            timer_seq_reg      <= '0;
            timer_idx_reg      <= '0;
            result_valid_reg   <= 1'b0;
        end
        else
        begin
            expected_reg       <= expected_next;
            exp_idx_reg        <= exp_idx_next;
            valid_reg          <= valid_next;
            timer_armed_reg    <= timer_armed_next;
            timer_deadline_reg <= timer_deadline_next;
            timer_seq_reg      <= timer_seq_next;
            timer_idx_reg      <= timer_idx_next;
            result_valid_reg   <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.emit_input && do_queue)
        begin
            tag_mem[in_idx] <= item_reg.tag[TAG_KEEP-1:0];
            exp_mem[in_idx] <= item_reg.expiry;
        end
        if (cmd.tag_read)
        begin
            tag_rd_reg <= tag_mem[exp_idx_reg];
        end
        if (cmd.exp_read)
        begin
            exp_rd_reg <= exp_mem[scan_idx_reg];
        end
        if (cmd.scan_start)
        begin
            scan_seq_reg <= expected_reg;
            scan_idx_reg <= exp_idx_reg;
            scan_cnt_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_seq_reg <= scan_seq_reg + 1'b1;
            scan_idx_reg <= scan_idx_step;
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
        end
        if (cmd.emit_input)
        begin
            result_reg.kind    <= in_kind;
            result_reg.seq_res <= item_reg.seq;
            result_reg.tag_res <= in_tag;
            result_reg.ack_due <= item_reg.ack_wanted;
            result_reg.last    <= in_last;
        end
        else if (cmd.emit_slot)
        begin
            result_reg.kind    <= seqrob_pkg::KIND_DELIVERED;
            result_reg.seq_res <= expected_reg;
            result_reg.tag_res <= seqrob_pkg::TAG_W'(tag_rd_reg);
            result_reg.ack_due <= 1'b0;
            result_reg.last    <= !more_after_adv;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef NO_ASSERTIONS
    a_drain_slot_held: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_slot |-> valid_reg[exp_idx_reg])
        else $error("drain delivers an empty slot");

    a_timer_points_at_unit: assert property (@(posedge clk) disable iff (!rst_n)
        timer_armed_reg |-> valid_reg[timer_idx_reg])
        else $error("gap timer armed for an empty slot");

    a_head_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        exp_idx_reg <= IDX_LAST)
        else $error("head slot index out of window");

    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !load)
        else $error("result overwritten while stalled");
`endif

endmodule

@@ design/sequence_reorder_buffer_core.sv @@
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_core
// Flow: a request is captured, then classified and its result loaded; a
//   delivery adds a drain check, each drained unit a tag read and a result
//   load, and a timer search after a drain walks the window slot by slot.
//   Result stalls hold the flow.
// Reset: asynchronous, active low; expected sequence 1, no slots, timer idle.
// ----------------------------------------------------------------------------
//
// In-order resequencer with a gap timeout.
//
// Each request is either a received unit or a time tick. Units with sequence
// zero pass straight through. Late units and duplicates are discarded, the
// expected unit is delivered, and anything ahead of the counter inside the
// window is parked in slot (seq mod WINDOW). After any delivery the buffer
// drains slots that have become consecutive, one at a time (tag store
// read, then result load).
//
// The gap timer tracks the earliest parked unit. When a tick reaches its
// deadline (expiry minus one, saturating at zero) the counter jumps to that
// unit and the normal drain runs. When the timer is idle after a drain, the
// controller walks the window one slot per cycle from the expected slot to
// find the next earliest unit and reads its expiry from the expiry store.
//
// The slot index of the counter is carried alongside it, so no modulo of a
// signal is ever needed: incoming slots are head index plus offset, folded
// once, and a counter wrap to zero resets the head index to zero.
//
// The result register parts the two sides; a new request is taken only once
// the previous one's work, including any timer search, has finished.
//
module sequence_reorder_buffer_core #(
    parameter int WINDOW   = 32,
    parameter int TAG_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    // received units and ticks
    input  logic                item_valid,
    output logic                item_stall,
    input  seqrob_pkg::item_t   item,
    // results
    output logic                result_valid,
    input  logic                result_stall,
    output seqrob_pkg::result_t result
);

    seqrob_pkg::cmd_t    cmd;
    seqrob_pkg::status_t status;

    // sequencer: owns the request handshake and orders the datapath steps
    seqrob_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: counter, slot stores, timer and the result register
    seqrob_datapath #(
        .WINDOW   (WINDOW),
        .TAG_BITS (TAG_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule
